### design/pbpb_pkg.sv
// Shared types and constants for the polyBLEP/polyBLAMP fixed-point correction unit.
// Holds the transaction payload structs, Q16/Q31 scale constants and the divider geometry.
// No dependencies.
package pbpb_pkg;

  // Q16 scales use 2^n-1 for unity
  localparam logic [31:0] HalfQ16   = 32'd32767;
  localparam logic [31:0] OneQ16    = 32'd65535;
  localparam logic [31:0] ThirdQ16  = 32'd21845;
  localparam logic [31:0] NegOneQ31 = 32'h8000_0001;
  localparam logic [31:0] ThirdQ31  = 32'd715827903;

  // Quotient is built four bits per pipeline stage
  localparam int QuoW      = 32;
  localparam int DivBits   = 4;
  localparam int DivStages = QuoW / DivBits;

  typedef enum logic [2:0] {
    KindNone,
    KindLead,
    KindTrail,
    KindLeadFlat,
    KindTrailFlat
  } kind_e;

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] phase_step;
  } pbpb_in_t;

  typedef struct packed {
    logic signed [31:0] step_correction;
    logic signed [31:0] ramp_correction;
  } pbpb_out_t;

endpackage

### design/polyblep_polyblamp_fixed_unit.sv
// PolyBLEP/polyBLAMP correction unit: pipelined divider, offset stage and three multiply stages.
// Depends on pbpb_pkg for payload structs, scale constants and divider geometry.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+--------------------------
//   in      | in  | in_valid_i / in_ready_o   | in_data_i  (pbpb_in_t)
//   out     | out | out_valid_o / out_ready_i | out_data_o (pbpb_out_t)
//
// One transaction per cycle while the output is not stalled. The stages are region decode, eight
// divider stages of four quotient bits each, sign, offset, three multiply stages and the output
// register. Each stage holds a valid bit and loads when it is empty or its successor loads, so
// bubbles collapse and a stall at the output holds each full stage back to the nearest empty one.
// Reset clears the valid bits only; the block takes transactions the cycle after reset.
module polyblep_polyblamp_fixed_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbpb_pkg::pbpb_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbpb_pkg::pbpb_out_t out_data_o
);

  localparam int StDec     = 0;
  localparam int StSign    = pbpb_pkg::DivStages + 1;
  localparam int StOff     = StSign + 1;
  localparam int StMul1    = StOff + 1;
  localparam int StMul2    = StMul1 + 1;
  localparam int StMul3    = StMul2 + 1;
  localparam int StOut     = StMul3 + 1;
  localparam int NumStages = StOut + 1;

  typedef struct packed {
    pbpb_pkg::kind_e kind;
    logic            neg;
    logic [15:0]     dvs;
    logic [15:0]     rem;
    logic [31:0]     dvd;
    logic [31:0]     quo;
  } div_t;

  function automatic logic [31:0] asr16(input logic [31:0] x);
    return {{16{x[31]}}, x[31:16]};
  endfunction

  // low word of the product, then arithmetic shift by 16
  function automatic logic [31:0] mul_q16(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] prod;
    prod = a * b;
    return asr16(prod);
  endfunction

  // restoring division, DivBits quotient bits
  function automatic div_t div_step(input div_t x);
    div_t        y;
    logic [16:0] trial;
    y = x;
    for (int k = 0; k < pbpb_pkg::DivBits; k++) begin
      trial = {y.rem, y.dvd[31]};
      y.dvd = {y.dvd[30:0], 1'b0};
      if (trial >= {1'b0, y.dvs}) begin
        y.rem = 16'(trial - {1'b0, y.dvs});
        y.quo = {y.quo[30:0], 1'b1};
      end else begin
        y.rem = trial[15:0];
        y.quo = {y.quo[30:0], 1'b0};
      end
    end
    return y;
  endfunction

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // a stage loads when empty or when its successor loads
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = en[StDec];
  assign out_valid_o = v_q[StOut];

  // ---------------- region decode ----------------
  div_t            div_q [pbpb_pkg::DivStages+1];
  div_t            dec_d;
  logic            lead;
  logic            trail;
  logic            zero_step;
  logic [15:0]     n16;
  pbpb_pkg::kind_e kind_dec;

  always_comb begin
    lead      = in_data_i.phase < in_data_i.phase_step;
    trail     = in_data_i.phase > ~in_data_i.phase_step;
    zero_step = in_data_i.phase_step[31:16] == 16'h0;
    // trailing dividend is (t16 - 65535) << 16 wrapped, i.e. int16(t16 + 1) * 65536
    n16 = in_data_i.phase[31:16] + 16'd1;
    if (lead) begin
      kind_dec = zero_step ? pbpb_pkg::KindLeadFlat : pbpb_pkg::KindLead;
    end else if (trail) begin
      kind_dec = zero_step ? pbpb_pkg::KindTrailFlat : pbpb_pkg::KindTrail;
    end else begin
      kind_dec = pbpb_pkg::KindNone;
    end
    dec_d.kind = kind_dec;
    dec_d.dvs  = in_data_i.phase_step[31:16];
    dec_d.rem  = '0;
    dec_d.quo  = '0;
    if (lead) begin
      dec_d.neg = 1'b0;
      dec_d.dvd = {in_data_i.phase[31:16], 16'h0};
    end else begin
      dec_d.neg = n16[15];
      dec_d.dvd = {(n16[15] ? 16'(16'h0 - n16) : n16), 16'h0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StDec]) begin
      div_q[0] <= dec_d;
    end
  end

  // ---------------- divider stages ----------------
  for (genvar g = 1; g <= pbpb_pkg::DivStages; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        div_q[g] <= div_step(div_q[g-1]);
      end
    end
  end

  // ---------------- sign and offset ----------------
  logic [31:0]     p_sign_d, p_sign_q;
  pbpb_pkg::kind_e kind_sign_q;
  logic [31:0]     p_off_q, a_off_d, a_off_q, c_off_d, c_off_q;
  pbpb_pkg::kind_e kind_off_q;
  logic            off_lead;

  always_comb begin
    p_sign_d = div_q[pbpb_pkg::DivStages].neg ? 32'h0 - div_q[pbpb_pkg::DivStages].quo
                                              : div_q[pbpb_pkg::DivStages].quo;
    off_lead = kind_sign_q == pbpb_pkg::KindLead;
    a_off_d  = off_lead ? p_sign_q - pbpb_pkg::OneQ16 : p_sign_q + pbpb_pkg::OneQ16;
    c_off_d  = off_lead ? 32'h0 - pbpb_pkg::ThirdQ16 : pbpb_pkg::ThirdQ16;
  end

  always_ff @(posedge clk_i) begin
    if (en[StSign]) begin
      p_sign_q    <= p_sign_d;
      kind_sign_q <= div_q[pbpb_pkg::DivStages].kind;
    end
    if (en[StOff]) begin
      p_off_q    <= p_sign_q;
      a_off_q    <= a_off_d;
      c_off_q    <= c_off_d;
      kind_off_q <= kind_sign_q;
    end
  end

  // ---------------- multiply stages ----------------
  logic [31:0]     h_m1_d, h_m1_q, b_m1_d, b_m1_q, p_m1_q, a_m1_q;
  pbpb_pkg::kind_e kind_m1_q;
  logic [31:0]     s_m2_d, s_m2_q, b_m2_d, b_m2_q, p_m2_q, a_m2_q;
  pbpb_pkg::kind_e kind_m2_q;
  logic [31:0]     b_m3_d, b_m3_q;
  logic [15:0]     sv_m3_d, sv_m3_q;
  pbpb_pkg::kind_e kind_m3_q;

  always_comb begin
    h_m1_d = mul_q16(p_off_q, pbpb_pkg::HalfQ16);
    b_m1_d = mul_q16(c_off_q, a_off_q);
    s_m2_d = mul_q16(h_m1_q, p_m1_q);
    b_m2_d = mul_q16(b_m1_q, a_m1_q);
    b_m3_d = mul_q16(b_m2_q, a_m2_q);
    // only the low half survives the final shift by 16
    if (kind_m2_q == pbpb_pkg::KindLead) begin
      sv_m3_d = p_m2_q[15:0] - s_m2_q[15:0] - pbpb_pkg::HalfQ16[15:0];
    end else begin
      sv_m3_d = p_m2_q[15:0] + s_m2_q[15:0] + pbpb_pkg::HalfQ16[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StMul1]) begin
      h_m1_q    <= h_m1_d;
      b_m1_q    <= b_m1_d;
      p_m1_q    <= p_off_q;
      a_m1_q    <= a_off_q;
      kind_m1_q <= kind_off_q;
    end
    if (en[StMul2]) begin
      s_m2_q    <= s_m2_d;
      b_m2_q    <= b_m2_d;
      p_m2_q    <= p_m1_q;
      a_m2_q    <= a_m1_q;
      kind_m2_q <= kind_m1_q;
    end
    if (en[StMul3]) begin
      b_m3_q    <= b_m3_d;
      sv_m3_q   <= sv_m3_d;
      kind_m3_q <= kind_m2_q;
    end
  end

  // ---------------- output ----------------
  pbpb_pkg::pbpb_out_t out_d, out_q;

  always_comb begin
    case (kind_m3_q)
      pbpb_pkg::KindLead, pbpb_pkg::KindTrail: begin
        out_d.step_correction = {sv_m3_q, 16'h0};
        out_d.ramp_correction = {b_m3_q[16:0], 15'h0};
      end
      pbpb_pkg::KindLeadFlat: begin
        out_d.step_correction = pbpb_pkg::NegOneQ31;
        out_d.ramp_correction = pbpb_pkg::ThirdQ31;
      end
      pbpb_pkg::KindTrailFlat: begin
        out_d.step_correction = pbpb_pkg::NegOneQ31;
        out_d.ramp_correction = pbpb_pkg::NegOneQ31;
      end
      default: begin
        out_d.step_correction = '0;
        out_d.ramp_correction = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTH
  // a full pipeline facing a stalled sink must refuse new input
  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline full and output stalled");

  // leading-region quotient never exceeds 65536
  a_lead_quotient_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[StSign] && kind_sign_q == pbpb_pkg::KindLead) |-> (p_sign_q <= 32'd65536))
    else $error("leading-region quotient out of range");

  // a valid entry in the last multiply stage reaches the output when it advances
  a_tail_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[StMul3] && en[StOut]) |=> v_q[StOut])
    else $error("transaction lost between multiply and output stage");
`endif

endmodule

### dv/polyblep_polyblamp_fixed_checker.sv
// Scoreboard for the polyBLEP/polyBLAMP correction unit: watches both channels,
// predicts each correction from the accepted phase pair and compares field by field.
// Depends on pbpb_pkg for the payload structs and the Q16/Q31 scale constants.
module polyblep_polyblamp_fixed_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  pbpb_pkg::pbpb_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  pbpb_pkg::pbpb_out_t out_data_i,
  output int                  err_count_o,
  output int                  pending_o
);

  pbpb_pkg::pbpb_out_t pending_corrections[$];
  pbpb_pkg::pbpb_out_t want;

  // Q16 product: keep the low word, then shift right arithmetically
  function automatic logic [31:0] q16_mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] prod;
    prod = a * b;
    return $unsigned($signed(prod) >>> 16);
  endfunction

  // Signed word over a positive divisor, truncating toward zero
  function automatic logic [31:0] q16_sdiv(input logic [31:0] num, input logic [31:0] den);
    longint n;
    longint d;
    longint q;
    n = longint'($signed(num));
    d = longint'(den);
    q = n / d;
    return q[31:0];
  endfunction

  function automatic pbpb_pkg::pbpb_out_t correction_of(input logic [31:0] t,
                                                        input logic [31:0] dt);
    pbpb_pkg::pbpb_out_t res;
    logic [31:0]         t16;
    logic [31:0]         d16;
    logic [31:0]         p;
    logic [31:0]         q;
    logic [31:0]         s;
    logic [31:0]         a;
    logic [31:0]         b;
    logic [31:0]         x;
    logic [31:0]         r;
    t16 = t >> 16;
    d16 = dt >> 16;
    res = '0;
    // Leading window wins when both windows hold
    if (t < dt) begin
      if (d16 == 32'd0) begin
        res.step_correction = pbpb_pkg::NegOneQ31;
        res.ramp_correction = pbpb_pkg::ThirdQ31;
      end else begin
        p = (t16 << 16) / d16;
        q = (p * pbpb_pkg::HalfQ16) >> 16;
        s = (q * p) >> 16;
        s = p - s - pbpb_pkg::HalfQ16;
        s = s + s;
        res.step_correction = s << 15;
        a = p - pbpb_pkg::OneQ16;
        b = q16_mul(32'd0 - pbpb_pkg::ThirdQ16, a);
        b = q16_mul(b, a);
        b = q16_mul(b, a);
        res.ramp_correction = b << 15;
      end
    end else if (t > ~dt) begin
      if (d16 == 32'd0) begin
        res.step_correction = pbpb_pkg::NegOneQ31;
        res.ramp_correction = pbpb_pkg::NegOneQ31;
      end else begin
        x = (t16 - pbpb_pkg::OneQ16) << 16;
        p = q16_sdiv(x, d16);
        x = q16_mul(q16_mul(p, pbpb_pkg::HalfQ16), p);
        q = p + x + pbpb_pkg::HalfQ16;
        q = q + q;
        res.step_correction = q << 15;
        r = p + pbpb_pkg::OneQ16;
        a = q16_mul(pbpb_pkg::ThirdQ16, r);
        a = q16_mul(a, r);
        a = q16_mul(a, r);
        res.ramp_correction = a << 15;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch: %s got %h exp %h", what, got, exp_val);
    err_count_o++;
  endtask

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  // Sample mid-cycle; the values hold until the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_corrections.size() == 0) begin
          report_mismatch("unexpected step_correction", out_data_i.step_correction, '0);
        end else begin
          want = pending_corrections.pop_front();
          if (out_data_i.step_correction !== want.step_correction)
            report_mismatch("step_correction", out_data_i.step_correction,
                            want.step_correction);
          if (out_data_i.ramp_correction !== want.ramp_correction)
            report_mismatch("ramp_correction", out_data_i.ramp_correction,
                            want.ramp_correction);
        end
      end
      if (in_valid_i && in_ready_i)
        pending_corrections.push_back(correction_of(in_data_i.phase, in_data_i.phase_step));
      pending_o = pending_corrections.size();
    end
  end

endmodule

### dv/polyblep_polyblamp_fixed_unit_test.sv
// Testbench top for the polyBLEP/polyBLAMP correction unit: clock, reset, phase stimulus,
// random idling on both channels and the final verdict.
// Depends on pbpb_pkg, polyblep_polyblamp_fixed_unit and polyblep_polyblamp_fixed_checker.
module polyblep_polyblamp_fixed_unit_test;

  localparam int RandomItems = 1080;
  localparam int IdleLimit   = 2000;
  localparam int TailCycles  = 40;

  typedef enum logic [2:0] {
    ShapeAny,
    ShapeLead,
    ShapeTrail,
    ShapeOutside,
    ShapeEdge
  } shape_e;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pbpb_pkg::pbpb_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  pbpb_pkg::pbpb_out_t out_data;
  int                  err_count;
  int                  pending;
  int                  in_burst;
  int                  out_burst;
  bit                  timed_out;

  polyblep_polyblamp_fixed_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  polyblep_polyblamp_fixed_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Random idle gap, with occasional stretches of back-to-back transactions
  function automatic int draw_gap(ref int burst);
    int gap;
    gap = 0;
    if (burst > 0) begin
      burst--;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 40);
    end
    return gap;
  endfunction

  task automatic send_phase(input logic [31:0] t, input logic [31:0] dt);
    int gap;
    bit took;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{phase: t, phase_step: dt};
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_random_phases();
    int          w;
    shape_e      shape;
    logic [31:0] t;
    logic [31:0] dt;
    for (int n = 0; n < RandomItems; n++) begin
      w = $urandom_range(0, 9);
      shape = (w < 2) ? ShapeAny : (w < 5) ? ShapeLead : (w < 8) ? ShapeTrail :
              (w < 9) ? ShapeOutside : ShapeEdge;
      t  = $urandom;
      dt = $urandom;
      // Shrink the step now and then so the truncated step gets small or zero
      if ($urandom_range(0, 3) == 0) dt = dt >> $urandom_range(0, 31);
      case (shape)
        ShapeLead: begin
          if (dt == 32'd0) dt = 32'd1;
          t = $urandom_range(dt - 32'd1, 0);
        end
        ShapeTrail: begin
          if (dt == 32'd0) dt = 32'd1;
          t = $urandom_range(32'hffff_ffff, ~dt + 32'd1);
        end
        ShapeOutside: begin
          dt = dt >> $urandom_range(4, 31);
          t  = $urandom_range(~dt, dt);
        end
        ShapeEdge: begin
          t = ($urandom_range(0, 1) ? dt : ~dt) + $urandom_range(0, 2) - 1;
        end
        default: ;
      endcase
      send_phase(t, dt);
    end
  endtask

  initial begin
    int  stall;
    bit  took;
    out_ready = 1'b0;
    out_burst = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(out_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    int idle;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    in_burst  = 0;
    timed_out = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        // outside both windows, zero truncated step
        send_phase(32'h0000_0000, 32'h0000_0000);
        send_phase(32'h8000_0000, 32'h0000_1000);
        // zero truncated step in each window
        send_phase(32'h0000_0000, 32'h0000_0001);
        send_phase(32'h0000_1234, 32'h0000_ffff);
        send_phase(32'hffff_ffff, 32'h0000_0001);
        send_phase(32'hffff_8000, 32'h0000_ffff);
        // leading window
        send_phase(32'h1000_0000, 32'h2000_0000);
        send_phase(32'h0000_0000, 32'hffff_ffff);
        send_phase(32'hffff_fffe, 32'hffff_ffff);
        send_phase(32'h0001_ffff, 32'h0002_0000);
        send_phase(32'h0000_ffff, 32'h0001_0000);
        // both windows hold: leading wins
        send_phase(32'h8000_0000, 32'h9000_0000);
        send_phase(32'h0000_8000, 32'hffff_9000);
        // trailing window
        send_phase(32'hf000_0000, 32'h2000_0000);
        send_phase(32'hffff_ffff, 32'hffff_ffff);
        send_phase(32'hffff_8000, 32'h0001_0000);
        send_phase(32'hfffe_1234, 32'h0001_ffff);
        send_phase(32'h8000_0001, 32'h8000_0000);
        // window boundaries
        send_phase(32'h3fff_ffff, 32'h4000_0000);
        send_phase(32'h4000_0000, 32'h4000_0000);
        send_phase(32'hbfff_ffff, 32'h4000_0000);
        send_phase(32'hc000_0000, 32'h4000_0000);
        send_random_phases();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
      end
      begin
        idle = 0;
        while (idle < IdleLimit) begin
          @(negedge clk);
          if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
          else idle++;
        end
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && err_count == 0 && pending == 0) begin
      $display("polyblep_polyblamp_fixed_unit regression: pass");
    end else begin
      $display("polyblep_polyblamp_fixed_unit regression: fail");
    end
    $finish;
  end

endmodule

### polyblep_polyblamp_fixed_unit.f
design/pbpb_pkg.sv
design/polyblep_polyblamp_fixed_unit.sv
dv/polyblep_polyblamp_fixed_checker.sv
dv/polyblep_polyblamp_fixed_unit_test.sv
